/* hdl/pfc_pkg.sv */
// Shared types, format codes and helpers for the pixel format converter.
`default_nettype none
package pfc_pkg;

    typedef enum logic [2:0] {
        FMT_A8       = 3'd0,
        FMT_I8       = 3'd1,
        FMT_IA88     = 3'd2,
        FMT_RGB888   = 3'd3,
        FMT_RGBA8888 = 3'd4
    } t_fmt;

    typedef enum logic [0:0] {
        REG_SOURCE_FORMAT = 1'b0,
        REG_TARGET_FORMAT = 1'b1
    } t_reg_idx;

    localparam int unsigned SUM_W  = 18;   // holds 255*1000 + 500
    localparam int unsigned PROD_W = 37;   // SUM_W + reciprocal width
    localparam int unsigned RECIP_SHIFT = 28;

    localparam logic [9:0]  LUMA_WR   = 10'd299;
    localparam logic [9:0]  LUMA_WG   = 10'd587;
    localparam logic [9:0]  LUMA_WB   = 10'd114;
    localparam logic [9:0]  LUMA_BIAS = 10'd500;
    // ceil(2^28 / 1000): exact floor(x / 1000) for every x below 2^18
    localparam logic [18:0] LUMA_RECIP = 19'd268436;

    localparam logic [7:0] BYTE_FULL = 8'hFF;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    typedef struct packed {
        logic [7:0] b3;
        logic [7:0] b2;
        logic [7:0] b1;
        logic [7:0] b0;
    } t_pix;

    typedef struct packed {
        t_pix       pix;
        logic [2:0] count;
    } t_res;

    // codes five to seven behave as RGBA8888
    function automatic t_fmt fmt_norm(input logic [2:0] raw);
        t_fmt f;
        f = (raw > 3'(FMT_RGBA8888)) ? FMT_RGBA8888 : t_fmt'(raw);
        return f;
    endfunction

    function automatic logic [2:0] fmt_size(input t_fmt f);
        logic [2:0] n;
        case (f)
            FMT_A8:       n = 3'd1;
            FMT_I8:       n = 3'd1;
            FMT_IA88:     n = 3'd2;
            FMT_RGB888:   n = 3'd3;
            default:      n = 3'd4;
        endcase
        return n;
    endfunction

    // weighted luma numerator, rounding bias included
    function automatic logic [SUM_W-1:0] luma_sum(input logic [7:0] r,
                                                  input logic [7:0] g,
                                                  input logic [7:0] b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(r) * SUM_W'(LUMA_WR) + SUM_W'(g) * SUM_W'(LUMA_WG)
          + SUM_W'(b) * SUM_W'(LUMA_WB) + SUM_W'(LUMA_BIAS);
        return s;
    endfunction

endpackage
`default_nettype wire

/* hdl/pfc_luma_div.sv */
// Divide the luma numerator by 1000 with a reciprocal multiply.
`default_nettype none
module pfc_luma_div
    import pfc_pkg::*;
(
    input  wire logic [SUM_W-1:0] i_sum,
    output logic      [7:0]       o_luma
);
    logic [PROD_W-1:0] prod;

    assign prod   = PROD_W'(i_sum) * PROD_W'(LUMA_RECIP);
    // quotient never exceeds 255
    assign o_luma = prod[RECIP_SHIFT+7:RECIP_SHIFT];
endmodule
`default_nettype wire

/* hdl/pfc_fmt_map.sv */
// Channel routing from source layout to target layout.
`default_nettype none
module pfc_fmt_map
    import pfc_pkg::*;
(
    input  wire t_fmt       i_src,
    input  wire t_fmt       i_tgt,
    input  wire t_pix       i_pix,
    input  wire logic [7:0] i_luma,
    output t_res            o_res
);
    t_pix       o;
    logic [7:0] alpha;
    logic [2:0] n;

    always_comb begin
        o     = '0;
        alpha = BYTE_FULL;
        n     = fmt_size(i_tgt);
        if (i_src == i_tgt
            || (i_src == FMT_I8 && i_tgt == FMT_A8)
            || (i_src == FMT_A8 && i_tgt == FMT_I8)) begin
            o = i_pix;
        end else if (i_src == FMT_A8) begin
            if (i_tgt == FMT_IA88) begin
                o.b0 = BYTE_FULL;
                o.b1 = i_pix.b0;
            end else if (i_tgt == FMT_RGBA8888) begin
                o.b3 = i_pix.b0;
            end
        end else if (i_src == FMT_I8 || i_src == FMT_IA88) begin
            alpha = (i_src == FMT_IA88) ? i_pix.b1 : BYTE_FULL;
            case (i_tgt)
                FMT_A8:   o.b0 = alpha;
                FMT_I8:   o.b0 = i_pix.b0;
                FMT_IA88: begin
                    o.b0 = i_pix.b0;
                    o.b1 = alpha;
                end
                default: begin
                    o.b0 = i_pix.b0;
                    o.b1 = i_pix.b0;
                    o.b2 = i_pix.b0;
                    o.b3 = alpha;
                end
            endcase
        end else begin
            alpha = (i_src == FMT_RGBA8888) ? i_pix.b3 : BYTE_FULL;
            case (i_tgt)
                FMT_A8:   o.b0 = (i_src == FMT_RGBA8888) ? i_pix.b3 : BYTE_ZERO;
                FMT_I8:   o.b0 = i_luma;
                FMT_IA88: begin
                    o.b0 = i_luma;
                    o.b1 = alpha;
                end
                default: begin
                    o.b0 = i_pix.b0;
                    o.b1 = i_pix.b1;
                    o.b2 = i_pix.b2;
                    o.b3 = alpha;
                end
            endcase
        end
        // bytes past the target size read as zero
        if (n < 3'd2) o.b1 = BYTE_ZERO;
        if (n < 3'd3) o.b2 = BYTE_ZERO;
        if (n < 3'd4) o.b3 = BYTE_ZERO;
        o_res.pix   = o;
        o_res.count = n;
    end
endmodule
`default_nettype wire

/* hdl/pixel_format_converter_top.sv */
// Top level of the pixel format converter: config registers and two-stage pipeline.
//
// Usage
//   Slave stream s_axis carries one pixel per transfer: tdata holds the four
//   source bytes (byte0 lowest), tlast marks the last pixel of a line.
//   Master stream m_axis returns one result per pixel: tdata holds four
//   target bytes, then the 3-bit byte count, zero padded to 40 bits; tlast
//   copies the line end mark. Bytes at or past the count are zero.
//   Config port: i_cfg_we with i_cfg_idx 0 sets the source format, 1 the
//   target format (0 A8, 1 I8, 2 IA88, 3 RGB888, 4 RGBA8888; 5..7 act as
//   RGBA8888). Write only while the pipeline is empty.
// Timing
//   Stage 1 registers the pixel and the weighted luma sum, stage 2 divides
//   by 1000 with a reciprocal multiply and routes channels into the output
//   register. m_axis_tvalid rises once the pixel has passed stage 1 and the
//   output register. Throughput is one pixel per cycle while the receiver
//   keeps tready high.
// Reset and stall
//   Synchronous active-low reset empties both stages and sets both formats
//   to RGBA8888. When the receiver holds tready low the output register
//   keeps its result, stage 1 fills, and s_axis_tready drops; no data lost.
`default_nettype none
module pixel_format_converter_top
    import pfc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write port
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [2:0]  i_cfg_wdata,
    // input pixel stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // in_byte0, in_byte1, in_byte2, in_byte3
    input  wire logic        s_axis_tlast,   // line_end_in
    // output pixel stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata,   // out_byte0..3, byte_count, 5 zero bits
    output logic             m_axis_tlast    // line_end_out
);
    // format registers, kept normalized
    t_fmt r_src, r_tgt;

    // stage 1: captured pixel and luma numerator
    logic             r_s1_valid;
    t_pix             r_s1_pix;
    logic [SUM_W-1:0] r_s1_sum;
    logic             r_s1_last;

    // stage 2: output register
    logic             r_out_valid;
    t_res             r_out_res;
    logic             r_out_last;

    logic       out_load;
    logic       in_xfer;
    t_pix       in_pix;
    logic [7:0] luma;
    t_res       res;

    assign in_pix   = t_pix'(s_axis_tdata);
    assign out_load = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || out_load;
    assign in_xfer  = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= FMT_RGBA8888;
            r_tgt <= FMT_RGBA8888;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_SOURCE_FORMAT: r_src <= fmt_norm(i_cfg_wdata);
                REG_TARGET_FORMAT: r_tgt <= fmt_norm(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_pix  <= in_pix;
            r_s1_sum  <= luma_sum(in_pix.b0, in_pix.b1, in_pix.b2);
            r_s1_last <= s_axis_tlast;
        end
    end

    pfc_luma_div u_luma_div (
        .i_sum  (r_s1_sum),
        .o_luma (luma)
    );

    pfc_fmt_map u_fmt_map (
        .i_src  (r_src),
        .i_tgt  (r_tgt),
        .i_pix  (r_s1_pix),
        .i_luma (luma),
        .o_res  (res)
    );

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_out_res  <= res;
            r_out_last <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_res.count, r_out_res.pix};
    assign m_axis_tlast  = r_out_last;
endmodule
`default_nettype wire

/* bench/pixel_format_converter_top_test.sv */
// Self-checking bench for pixel_format_converter_top: directed table plus random format phases.
`default_nettype none
module pixel_format_converter_top_test
    import pfc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_PCT     = 31;  // chance of an idle cycle on either side
    localparam int unsigned HOLD_CYCLES  = 80;  // long receiver hold-off
    localparam int unsigned DRAIN_CYCLES = 4;   // pipeline is 2 deep, leave some margin
    localparam int unsigned PAIR_PHASES  = 25;  // every source/target pair once
    localparam int unsigned ALIAS_PHASES = 5;   // phases with codes five to seven
    localparam int unsigned HOLD_PHASE   = 5;
    localparam int unsigned CALM_FIRST   = 12;
    localparam int unsigned CALM_LAST    = 13;

    // format codes above RGBA8888 act as RGBA8888
    localparam logic [2:0] FMT_ALIAS5 = 3'd5;
    localparam logic [2:0] FMT_ALIAS6 = 3'd6;
    localparam logic [2:0] FMT_ALIAS7 = 3'd7;

    // BT.601 luma weights and rounding
    localparam int unsigned Y_WR   = 299;
    localparam int unsigned Y_WG   = 587;
    localparam int unsigned Y_WB   = 114;
    localparam int unsigned Y_BIAS = 500;
    localparam int unsigned Y_DIV  = 1000;

    // one converted pixel: bytes packed b3..b0 from the top
    typedef struct packed {
        logic       eol;
        logic [2:0] cnt;
        logic [31:0] pix;
    } t_pix_res;

    typedef struct packed {
        logic [2:0]  src;
        logic [2:0]  dst;
        logic [31:0] pix;
        logic        eol;
        logic        typed;     // expectation written in the row
        logic [31:0] exp_pix;
        logic [2:0]  exp_cnt;
    } t_dir_row;

    localparam int unsigned DIR_N = 25;
    // rows with typed = 0 are checked against the predictor
    localparam t_dir_row DIR_TAB [DIR_N] = '{
        // reset formats, no config write yet
        '{FMT_RGBA8888, FMT_RGBA8888, 32'h00000000, 1'b0, 1'b1, 32'h00000000, 3'd4},
        '{FMT_RGBA8888, FMT_RGBA8888, 32'hFFFFFFFF, 1'b1, 1'b1, 32'hFFFFFFFF, 3'd4},
        // luma extremes, unused source byte ignored
        '{FMT_RGB888,   FMT_I8,       32'hA5FFFFFF, 1'b0, 1'b1, 32'h000000FF, 3'd1},
        '{FMT_RGB888,   FMT_I8,       32'h5A000000, 1'b1, 1'b1, 32'h00000000, 3'd1},
        '{FMT_RGB888,   FMT_I8,       32'h00000002, 1'b0, 1'b0, 32'h0,        3'd0},
        // alpha-only source or target
        '{FMT_A8,       FMT_IA88,     32'hC3B2A15A, 1'b0, 1'b1, 32'h00005AFF, 3'd2},
        '{FMT_A8,       FMT_RGB888,   32'hFFFFFFFF, 1'b1, 1'b1, 32'h00000000, 3'd3},
        '{FMT_A8,       FMT_RGBA8888, 32'h123456A7, 1'b0, 1'b1, 32'hA7000000, 3'd4},
        '{FMT_RGB888,   FMT_A8,       32'hFFFFFFFF, 1'b0, 1'b1, 32'h00000000, 3'd1},
        // single-byte formats swap unchanged
        '{FMT_I8,       FMT_A8,       32'hFFFFFF80, 1'b1, 1'b1, 32'h00000080, 3'd1},
        '{FMT_A8,       FMT_I8,       32'h0000007F, 1'b0, 1'b1, 32'h0000007F, 3'd1},
        // gray expansion
        '{FMT_I8,       FMT_RGBA8888, 32'h9988773C, 1'b0, 1'b1, 32'hFF3C3C3C, 3'd4},
        '{FMT_IA88,     FMT_RGBA8888, 32'h000011C8, 1'b1, 1'b1, 32'h11C8C8C8, 3'd4},
        '{FMT_IA88,     FMT_A8,       32'h000011C8, 1'b0, 1'b1, 32'h00000011, 3'd1},
        // same source and target, upper bytes cleared
        '{FMT_IA88,     FMT_IA88,     32'hDEADBEEF, 1'b0, 1'b1, 32'h0000BEEF, 3'd2},
        '{FMT_RGB888,   FMT_RGB888,   32'hDEADBEEF, 1'b1, 1'b1, 32'h00ADBEEF, 3'd3},
        '{FMT_RGBA8888, FMT_A8,       32'h80FFFFFF, 1'b0, 1'b1, 32'h00000080, 3'd1},
        '{FMT_RGBA8888, FMT_IA88,     32'h40102030, 1'b0, 1'b0, 32'h0,        3'd0},
        '{FMT_RGB888,   FMT_RGBA8888, 32'h77102030, 1'b1, 1'b1, 32'hFF102030, 3'd4},
        '{FMT_I8,       FMT_IA88,     32'h00000055, 1'b0, 1'b1, 32'h0000FF55, 3'd2},
        '{FMT_I8,       FMT_RGB888,   32'h00000055, 1'b0, 1'b0, 32'h0,        3'd0},
        '{FMT_RGBA8888, FMT_RGB888,   32'hFF010203, 1'b0, 1'b1, 32'h00010203, 3'd3},
        // codes five to seven
        '{FMT_ALIAS7,   FMT_ALIAS5,   32'hDEADBEEF, 1'b1, 1'b1, 32'hDEADBEEF, 3'd4},
        '{FMT_ALIAS6,   FMT_I8,       32'h00FFFFFF, 1'b0, 1'b0, 32'h0,        3'd0},
        '{FMT_I8,       FMT_ALIAS7,   32'h000000AB, 1'b0, 1'b1, 32'hFFABABAB, 3'd4}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [0:0]  i_cfg_idx     = REG_SOURCE_FORMAT;
    logic [2:0]  i_cfg_wdata   = 3'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = 32'd0;   // in_byte0, in_byte1, in_byte2, in_byte3
    logic        s_axis_tlast  = 1'b0;    // line_end_in
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;            // out_byte0..3, byte_count, 5 pad bits
    logic        m_axis_tlast;            // line_end_out

    // bench copy of the format registers
    logic [2:0]  cfg_src = FMT_RGBA8888;
    logic [2:0]  cfg_dst = FMT_RGBA8888;

    t_pix_res    pix_expect_q [$];
    int unsigned fail_cnt = 0;

    // receiver pacing controls, driven by the stimulus process
    logic        hold_req  = 1'b0;
    logic        calm      = 1'b0;
    logic        hold_done = 1'b0;
    int unsigned hold_left = 0;

    pixel_format_converter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Conversion predictor
    // ------------------------------------------------------------------
    function automatic t_fmt fold_fmt(input logic [2:0] code);
        t_fmt f;
        if (code > 3'(FMT_RGBA8888)) f = FMT_RGBA8888;
        else f = t_fmt'(code);
        return f;
    endfunction

    function automatic logic [7:0] bt601_gray(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
        int unsigned acc;
        acc = r * Y_WR + g * Y_WG + b * Y_WB + Y_BIAS;
        return 8'(acc / Y_DIV);
    endfunction

    function automatic t_pix_res convert_pixel(input logic [2:0] src_code,
                                               input logic [2:0] dst_code,
                                               input logic [31:0] pix,
                                               input logic eol);
        t_fmt       s;
        t_fmt       d;
        logic [7:0] ib [4];
        logic [7:0] ob [4];
        logic [7:0] alpha;
        logic [2:0] n;
        t_pix_res   res;
        s = fold_fmt(src_code);
        d = fold_fmt(dst_code);
        for (int k = 0; k < 4; k++) begin
            ib[k] = pix[8*k +: 8];
            ob[k] = BYTE_ZERO;
        end
        case (d)
            FMT_A8, FMT_I8: n = 3'd1;
            FMT_IA88:       n = 3'd2;
            FMT_RGB888:     n = 3'd3;
            default:        n = 3'd4;
        endcase
        if (s == d || (s == FMT_I8 && d == FMT_A8) || (s == FMT_A8 && d == FMT_I8)) begin
            ob = ib;
        end else if (s == FMT_A8) begin
            // alpha only: black colour, or white gray for IA88
            if (d == FMT_IA88) begin
                ob[0] = BYTE_FULL;
                ob[1] = ib[0];
            end else if (d == FMT_RGBA8888) begin
                ob[3] = ib[0];
            end
        end else if (s == FMT_I8 || s == FMT_IA88) begin
            alpha = (s == FMT_IA88) ? ib[1] : BYTE_FULL;
            case (d)
                FMT_A8:   ob[0] = alpha;
                FMT_I8:   ob[0] = ib[0];
                FMT_IA88: begin
                    ob[0] = ib[0];
                    ob[1] = alpha;
                end
                default: begin
                    ob[0] = ib[0];
                    ob[1] = ib[0];
                    ob[2] = ib[0];
                    ob[3] = alpha;
                end
            endcase
        end else begin
            alpha = (s == FMT_RGBA8888) ? ib[3] : BYTE_FULL;
            case (d)
                FMT_A8:   ob[0] = (s == FMT_RGBA8888) ? ib[3] : BYTE_ZERO;
                FMT_I8:   ob[0] = bt601_gray(ib[0], ib[1], ib[2]);
                FMT_IA88: begin
                    ob[0] = bt601_gray(ib[0], ib[1], ib[2]);
                    ob[1] = alpha;
                end
                default: begin
                    ob[0] = ib[0];
                    ob[1] = ib[1];
                    ob[2] = ib[2];
                    ob[3] = alpha;
                end
            endcase
        end
        // bytes past the count are zero
        for (int k = 0; k < 4; k++) begin
            res.pix[8*k +: 8] = (k < n) ? ob[k] : BYTE_ZERO;
        end
        res.cnt = n;
        res.eol = eol;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_byte();
        logic [7:0] v;
        case ($urandom_range(0, 7))
            0:       v = BYTE_ZERO;
            1:       v = BYTE_FULL;
            default: v = 8'($urandom);
        endcase
        return v;
    endfunction

    // one pixel transfer; pushes the typed or predicted result on acceptance
    task automatic send_pixel(input logic [31:0] pix, input logic eol,
                              input logic typed, input t_pix_res typed_res);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tlast  <= eol;
        do @(posedge i_clk); while (!s_axis_tready);
        if (typed) pix_expect_q.push_back(typed_res);
        else pix_expect_q.push_back(convert_pixel(cfg_src, cfg_dst, pix, eol));
    endtask

    // write both format registers with the pipeline empty
    task automatic set_formats(input logic [2:0] src, input logic [2:0] dst);
        s_axis_tvalid <= 1'b0;
        while (pix_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_SOURCE_FORMAT;
        i_cfg_wdata <= src;
        @(posedge i_clk);
        i_cfg_idx   <= REG_TARGET_FORMAT;
        i_cfg_wdata <= dst;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_src = src;
        cfg_dst = dst;
    endtask

    // ------------------------------------------------------------------
    // Receiver pacing: random stalls, one long hold-off, calm stretch
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 1) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            hold_left     <= 0;
            m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic cmp_field(input string name, input int unsigned want,
                             input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d (0x%0h), got %0d (0x%0h)",
                   name, want, want, got, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pix_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pix_expect_q.size() == 0) begin
                $error("unexpected transfer: tdata 0x%0h tlast %0b",
                       m_axis_tdata, m_axis_tlast);
                fail_cnt++;
            end else begin
                want = pix_expect_q.pop_front();
                cmp_field("out_byte0",    want.pix[7:0],   m_axis_tdata[7:0]);
                cmp_field("out_byte1",    want.pix[15:8],  m_axis_tdata[15:8]);
                cmp_field("out_byte2",    want.pix[23:16], m_axis_tdata[23:16]);
                cmp_field("out_byte3",    want.pix[31:24], m_axis_tdata[31:24]);
                cmp_field("byte_count",   want.cnt,        m_axis_tdata[34:32]);
                cmp_field("tdata_pad",    0,               m_axis_tdata[39:35]);
                cmp_field("line_end_out", want.eol,        m_axis_tlast);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_pix_res    typed_res;
        logic [2:0]  src;
        logic [2:0]  dst;
        int unsigned n_pix;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; reconfigure only when the row asks for other formats
        for (int r = 0; r < DIR_N; r++) begin
            if (DIR_TAB[r].src != cfg_src || DIR_TAB[r].dst != cfg_dst)
                set_formats(DIR_TAB[r].src, DIR_TAB[r].dst);
            typed_res.pix = DIR_TAB[r].exp_pix;
            typed_res.cnt = DIR_TAB[r].exp_cnt;
            typed_res.eol = DIR_TAB[r].eol;
            send_pixel(DIR_TAB[r].pix, DIR_TAB[r].eol, DIR_TAB[r].typed, typed_res);
        end

        // random phases: all 25 pairs, then phases using codes five to seven
        for (int p = 0; p < PAIR_PHASES + ALIAS_PHASES; p++) begin
            if (p < PAIR_PHASES) begin
                src = 3'(p / 5);
                dst = 3'(p % 5);
            end else begin
                src = 3'($urandom_range(0, 7));
                dst = 3'($urandom_range(0, 7));
                if (src <= 3'(FMT_RGBA8888) && dst <= 3'(FMT_RGBA8888))
                    dst = 3'($urandom_range(FMT_ALIAS5, FMT_ALIAS7));
            end
            set_formats(src, dst);
            calm     <= (p >= CALM_FIRST && p <= CALM_LAST);
            // long receiver hold-off while the sender keeps offering
            if (p == HOLD_PHASE) hold_req <= 1'b1;
            n_pix = (p == HOLD_PHASE) ? 40 : $urandom_range(18, 28);
            for (int i = 0; i < n_pix; i++)
                send_pixel({pick_byte(), pick_byte(), pick_byte(), pick_byte()},
                           ($urandom_range(0, 7) == 0), 1'b0, typed_res);
        end

        s_axis_tvalid <= 1'b0;
        while (pix_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES + 4) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("pixel_format_converter_top_test: clean");
        else
            $display("pixel_format_converter_top_test: errors");
        $finish;
    end

    // run limit, far above the slowest legal run
    initial begin
        #1_000_000;
        $display("timeout waiting for results");
        $display("pixel_format_converter_top_test: errors");
        $finish;
    end

endmodule
`default_nettype wire
